// ===== rtl/meb_pkg.sv =====
// shared types and constants for the mandelbrot escape-time pixel core
package meb_pkg;

  localparam int PixW     = 10;
  localparam int CenterW  = 48;
  localparam int RadW     = 47;
  localparam int IterW    = 16;
  localparam int ColorW   = 8;
  localparam int CfgDataW = 48;
  localparam int CfgIdxW  = 2;
  localparam int ZW       = 64;
  localparam int HalfW    = ZW / 2;
  localparam int AccW     = 2 * ZW;
  localparam int DivW     = RadW + 1 + PixW;

  localparam int ImageWidthDef  = 800;
  localparam int ImageHeightDef = 800;
  localparam int FracBitsDef    = 44;

  localparam logic [CenterW-1:0] CenterRealRst = 48'hF800_0000_0000;
  localparam logic [CenterW-1:0] CenterImagRst = '0;
  localparam logic [RadW-1:0]    RadiusRst     = 47'h1000_0000_0000;
  localparam logic [IterW-1:0]   MaxIterRst    = 16'd1000;
  localparam logic [AccW-1:0]    EscLimit      = AccW'(100000000);

  typedef enum logic [CfgIdxW-1:0] {
    RegCenterReal = 2'd0,
    RegCenterImag = 2'd1,
    RegViewRadius = 2'd2,
    RegMaxIter    = 2'd3
  } meb_reg_e;

  typedef struct packed {
    logic       start;
    logic       init;
    logic       z_load;
    logic       mag_load;
    logic       mul_en;
    logic [1:0] mul_step;
    logic       acc_en;
    logic [1:0] acc_step;
    logic       chk_load;
    logic       k_inc;
    logic       res_zero;
    logic       res_k;
    logic       push;
  } meb_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic k_at_limit;
    logic ovf;
    logic esc;
  } meb_sts_t;

endpackage

// ===== rtl/mandelbrot_escape_time_pixel_core.sv =====
// top level of the mandelbrot escape-time pixel core
//
//  channel  | handshake                      | payload
//  ---------+--------------------------------+------------------------------
//  in       | in_valid_i / in_ready_o        | pixel_x_i, pixel_y_i
//  out      | out_valid_o / out_ready_i      | color_index_o
//  cfg      | cfg_we_i (no wait)             | cfg_idx_i, cfg_wdata_i
//
//  a pixel runs at most max_iterations - 1 full iterations, and the |z|^2 test can end it
//  early; out stalls hold the core in its result state and add to the time of a pixel
//  mapping divides by the image size with a reciprocal multiply in 32x32 steps;
//  each squaring is built from four 32x32 partial products
//  reset loads the default view and limit and leaves the core idle
//  a finished result waits in the output register while the next pixel runs; the
//  next one waits in the core until that beat is taken
module mandelbrot_escape_time_pixel_core
  import meb_pkg::*;
#(
  parameter int IMAGE_WIDTH  = ImageWidthDef,
  parameter int IMAGE_HEIGHT = ImageHeightDef,
  parameter int FRAC_BITS    = FracBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [PixW-1:0]     pixel_x_i,
  input  logic [PixW-1:0]     pixel_y_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [ColorW-1:0]   color_index_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  meb_cmd_t cmd;
  meb_sts_t sts;

  meb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  meb_dp #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT),
    .FRAC_BITS    (FRAC_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .pixel_x_i     (pixel_x_i),
    .pixel_y_i     (pixel_y_i),
    .color_index_o (color_index_o)
  );

endmodule

// ===== rtl/meb_div.sv =====
// divider by a constant: reciprocal multiply over four 32x32 partial products
module meb_div
  import meb_pkg::*;
#(
  parameter int DIVISOR = ImageWidthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DivW-1:0] dividend_i,
  output logic            busy_o,
  output logic [DivW-1:0] quot_o
);

  localparam int ShW = DivW + $clog2(DIVISOR);
  localparam logic [AccW-1:0] RecipW =
    ((AccW'(1) << ShW) + AccW'(DIVISOR - 1)) / AccW'(DIVISOR);
  localparam logic [ZW-1:0] Recip = RecipW[ZW-1:0];
  localparam logic [2:0] StepLast = 3'd4;

  logic             busy_q, busy_d;
  logic [2:0]       cnt_q, cnt_d;
  logic [ZW-1:0]    dvd_q;
  logic [ZW-1:0]    prod_q;
  logic [1:0]       prod_step_q;
  logic [AccW-1:0]  acc_q;
  logic [HalfW-1:0] op_a, op_b;
  logic [6:0]       acc_sh;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 3'd1;
      if (cnt_q == StepLast) begin
        busy_d = 1'b0;
      end
    end
  end

  always_comb begin
    op_a = cnt_q[0] ? dvd_q[ZW-1:HalfW] : dvd_q[HalfW-1:0];
    op_b = cnt_q[1] ? Recip[ZW-1:HalfW] : Recip[HalfW-1:0];
    case (prod_step_q)
      2'd0:    acc_sh = 7'd0;
      2'd3:    acc_sh = 7'(2 * HalfW);
      default: acc_sh = 7'(HalfW);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= ZW'(dividend_i);
      acc_q <= '0;
    end else if (busy_q) begin
      if (cnt_q != StepLast) begin
        prod_q      <= ZW'(op_a) * ZW'(op_b);
        prod_step_q <= cnt_q[1:0];
      end
      if (cnt_q != '0) begin
        acc_q <= acc_q + (AccW'(prod_q) << acc_sh);
      end
    end
  end

  assign busy_o = busy_q;
  assign quot_o = acc_q[ShW +: DivW];

endmodule

// ===== rtl/meb_dp.sv =====
// datapath: config registers, coordinate mapping, z iteration and result register
module meb_dp
  import meb_pkg::*;
#(
  parameter int IMAGE_WIDTH  = ImageWidthDef,
  parameter int IMAGE_HEIGHT = ImageHeightDef,
  parameter int FRAC_BITS    = FracBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  meb_cmd_t            cmd_i,
  output meb_sts_t            sts_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic [PixW-1:0]     pixel_x_i,
  input  logic [PixW-1:0]     pixel_y_i,
  output logic [ColorW-1:0]   color_index_o
);

  logic [CenterW-1:0] center_real_q, center_imag_q;
  logic [RadW-1:0]    radius_q;
  logic [IterW-1:0]   max_iter_q;

  logic [DivW-1:0] dvd_x, dvd_y, quot_x, quot_y;
  logic            busy_x, busy_y;

  logic [ZW-1:0]   cre_q, cim_q, zr_q, zi_q, ar_q, ai_q;
  logic            neg_q;
  logic [ZW-1:0]   p_rr_q, p_ii_q, p_ri_q;
  logic [AccW-1:0] acc_rr_q, acc_ii_q, acc_ri_q;
  logic [AccW-1:0] diff_q, crs_q;
  logic [IterW-1:0]  k_q;
  logic [ColorW-1:0] res_q, color_q;

  logic [ZW-1:0]    cre_d, cim_d;
  logic [AccW-1:0]  nr, ni, msum, m_shr;
  logic             fits_r, fits_i;
  logic [HalfW-1:0] ah_r, bh_r, ah_i, bh_i;
  logic [6:0]       acc_sh;

  // config port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_real_q <= CenterRealRst;
      center_imag_q <= CenterImagRst;
      radius_q      <= RadiusRst;
      max_iter_q    <= MaxIterRst;
    end else if (cfg_we_i) begin
      case (meb_reg_e'(cfg_idx_i))
        RegCenterReal: center_real_q <= cfg_wdata_i;
        RegCenterImag: center_imag_q <= cfg_wdata_i;
        RegViewRadius: radius_q      <= cfg_wdata_i[RadW-1:0];
        RegMaxIter:    max_iter_q    <= cfg_wdata_i[IterW-1:0];
        default: ;
      endcase
    end
  end

  // 2 * radius * pixel, then divide by the image size
  assign dvd_x = DivW'({radius_q, 1'b0}) * DivW'(pixel_x_i);
  assign dvd_y = DivW'({radius_q, 1'b0}) * DivW'(pixel_y_i);

  meb_div #(.DIVISOR(IMAGE_WIDTH)) u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.start),
    .dividend_i (dvd_x),
    .busy_o     (busy_x),
    .quot_o     (quot_x)
  );

  meb_div #(.DIVISOR(IMAGE_HEIGHT)) u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.start),
    .dividend_i (dvd_y),
    .busy_o     (busy_y),
    .quot_o     (quot_y)
  );

  always_comb begin
    cre_d = {{(ZW-CenterW){center_real_q[CenterW-1]}}, center_real_q}
            - ZW'(radius_q) + ZW'(quot_x);
    cim_d = {{(ZW-CenterW){center_imag_q[CenterW-1]}}, center_imag_q}
            - ZW'(radius_q) + ZW'(quot_y);
  end

  // next z from the registered difference and cross term
  always_comb begin
    nr = AccW'($signed(diff_q) >>> FRAC_BITS)
         + {{(AccW-ZW){cre_q[ZW-1]}}, cre_q};
    ni = AccW'($signed(crs_q) >>> (FRAC_BITS - 1))
         + {{(AccW-ZW){cim_q[ZW-1]}}, cim_q};
    fits_r = nr[AccW-1:ZW-1] == {(AccW-ZW+1){nr[ZW-1]}};
    fits_i = ni[AccW-1:ZW-1] == {(AccW-ZW+1){ni[ZW-1]}};
  end

  // escape test on |z|^2
  always_comb begin
    msum  = acc_rr_q + acc_ii_q;
    m_shr = msum >> (2 * FRAC_BITS);
  end

  // partial product operand halves
  always_comb begin
    ah_r = cmd_i.mul_step[0] ? ar_q[ZW-1:HalfW] : ar_q[HalfW-1:0];
    bh_r = cmd_i.mul_step[1] ? ar_q[ZW-1:HalfW] : ar_q[HalfW-1:0];
    ah_i = cmd_i.mul_step[0] ? ai_q[ZW-1:HalfW] : ai_q[HalfW-1:0];
    bh_i = cmd_i.mul_step[1] ? ai_q[ZW-1:HalfW] : ai_q[HalfW-1:0];
    case (cmd_i.acc_step)
      2'd0:    acc_sh = 7'd0;
      2'd3:    acc_sh = 7'(2 * HalfW);
      default: acc_sh = 7'(HalfW);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      cre_q  <= cre_d;
      cim_q  <= cim_d;
      diff_q <= '0;
      crs_q  <= '0;
      k_q    <= IterW'(1);
    end else begin
      if (cmd_i.chk_load) begin
        diff_q <= acc_rr_q - acc_ii_q;
        crs_q  <= neg_q ? (AccW'(0) - acc_ri_q) : acc_ri_q;
      end
      if (cmd_i.k_inc) begin
        k_q <= k_q + IterW'(1);
      end
    end
    if (cmd_i.z_load) begin
      zr_q     <= nr[ZW-1:0];
      zi_q     <= ni[ZW-1:0];
      acc_rr_q <= '0;
      acc_ii_q <= '0;
      acc_ri_q <= '0;
    end else if (cmd_i.acc_en) begin
      acc_rr_q <= acc_rr_q + (AccW'(p_rr_q) << acc_sh);
      acc_ii_q <= acc_ii_q + (AccW'(p_ii_q) << acc_sh);
      acc_ri_q <= acc_ri_q + (AccW'(p_ri_q) << acc_sh);
    end
    if (cmd_i.mag_load) begin
      ar_q  <= zr_q[ZW-1] ? (ZW'(0) - zr_q) : zr_q;
      ai_q  <= zi_q[ZW-1] ? (ZW'(0) - zi_q) : zi_q;
      neg_q <= zr_q[ZW-1] ^ zi_q[ZW-1];
    end
    if (cmd_i.mul_en) begin
      p_rr_q <= ZW'(ah_r) * ZW'(bh_r);
      p_ii_q <= ZW'(ah_i) * ZW'(bh_i);
      p_ri_q <= ZW'(ah_r) * ZW'(bh_i);
    end
    if (cmd_i.res_zero) begin
      res_q <= '0;
    end else if (cmd_i.res_k) begin
      res_q <= k_q[ColorW-1:0];
    end
    if (cmd_i.push) begin
      color_q <= res_q;
    end
  end

  assign sts_o.div_busy   = busy_x | busy_y;
  assign sts_o.k_at_limit = k_q >= max_iter_q;
  assign sts_o.ovf        = !fits_r || !fits_i;
  assign sts_o.esc        = m_shr >= EscLimit;
  assign color_index_o    = color_q;

endmodule

// ===== rtl/meb_ctrl.sv =====
// controller: sequencing of mapping, iteration steps and the output beat
module meb_ctrl
  import meb_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  meb_sts_t sts_i,
  output meb_cmd_t cmd_o
);

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StDiv   = 7'b0000010,
    StInit  = 7'b0000100,
    StUpd   = 7'b0001000,
    StMul   = 7'b0010000,
    StCheck = 7'b0100000,
    StHold  = 7'b1000000
  } meb_state_e;

  localparam logic [2:0] MulLast = 3'd5;

  meb_state_e state_q, state_d;
  logic [2:0] cnt_q, cnt_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = StDiv;
        end
      end
      StDiv: begin
        if (!sts_i.div_busy) begin
          state_d = StInit;
        end
      end
      StInit: begin
        cmd_o.init = 1'b1;
        state_d    = StUpd;
      end
      StUpd: begin
        if (sts_i.k_at_limit) begin
          cmd_o.res_zero = 1'b1;
          state_d        = StHold;
        end else if (sts_i.ovf) begin
          cmd_o.res_k = 1'b1;
          state_d     = StHold;
        end else begin
          cmd_o.z_load = 1'b1;
          cnt_d        = '0;
          state_d      = StMul;
        end
      end
      StMul: begin
        cmd_o.mag_load = cnt_q == '0;
        cmd_o.mul_en   = cnt_q inside {[3'd1:3'd4]};
        cmd_o.mul_step = 2'(cnt_q - 3'd1);
        cmd_o.acc_en   = cnt_q inside {[3'd2:MulLast]};
        cmd_o.acc_step = 2'(cnt_q - 3'd2);
        cnt_d          = cnt_q + 3'd1;
        if (cnt_q == MulLast) begin
          state_d = StCheck;
        end
      end
      StCheck: begin
        cmd_o.chk_load = 1'b1;
        if (sts_i.esc) begin
          cmd_o.res_k = 1'b1;
          state_d     = StHold;
        end else begin
          cmd_o.k_inc = 1'b1;
          state_d     = StUpd;
        end
      end
      StHold: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.push = 1'b1;
          state_d    = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.push) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == StIdle;
  assign out_valid_o = out_valid_q;

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.push |-> (!out_valid_q || out_ready_i))
    else $error("result pushed into a full output register");

  a_idle_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !sts_i.div_busy)
    else $error("divider busy while idle");

  a_start_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> sts_i.div_busy)
    else $error("divider did not start on input beat");

  a_res_k_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_k |-> !sts_i.k_at_limit)
    else $error("escape reported at or past the iteration limit");

  a_mul_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMul) |-> (cnt_q <= MulLast))
    else $error("multiply step counter out of range");

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for the mandelbrot escape-time pixel core
`timescale 1ns / 1ps

module tb_top;
  import meb_pkg::*;

  localparam int ImgW       = ImageWidthDef;
  localparam int ImgH       = ImageHeightDef;
  localparam int FracBits   = FracBitsDef;
  localparam int CycleLimit = 3_000_000;

  typedef struct packed {
    logic [PixW-1:0] x;
    logic [PixW-1:0] y;
  } pixel_t;

  typedef struct packed {
    logic [PixW-1:0]   x;
    logic [PixW-1:0]   y;
    logic [ColorW-1:0] color;
  } color_exp_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [PixW-1:0]     pixel_x = '0;
  logic [PixW-1:0]     pixel_y = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [ColorW-1:0]   color_index;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = RegCenterReal;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  logic [CenterW-1:0] cfg_center_re = CenterRealRst;
  logic [CenterW-1:0] cfg_center_im = CenterImagRst;
  logic [RadW-1:0]    cfg_radius    = RadiusRst;
  logic [IterW-1:0]   cfg_max_iter  = MaxIterRst;

  pixel_t     pixel_q[$];
  color_exp_t color_q[$];
  pixel_t     drv_pix;
  color_exp_t mon_exp;

  int send_idle_pct = 37;
  int recv_idle_pct = 50;
  int queued_cnt    = 0;
  int accepted_cnt  = 0;
  int checked_cnt   = 0;
  int view_cnt      = 1;
  int errors        = 0;
  int cycle_cnt     = 0;

  mandelbrot_escape_time_pixel_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .pixel_x_i     (pixel_x),
    .pixel_y_i     (pixel_y),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .color_index_o (color_index),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [ColorW-1:0] escape_color(logic [PixW-1:0] px,
                                                     logic [PixW-1:0] py);
    logic [63:0]         term_re;
    logic [63:0]         term_im;
    logic signed [63:0]  c_re;
    logic signed [63:0]  c_im;
    logic signed [63:0]  z_re;
    logic signed [63:0]  z_im;
    logic signed [127:0] cr_w;
    logic signed [127:0] ci_w;
    logic signed [127:0] zr_w;
    logic signed [127:0] zi_w;
    logic signed [127:0] nr;
    logic signed [127:0] ni;
    logic [127:0]        mag;
    term_re = (64'(cfg_radius) * 64'd2 * 64'(px)) / 64'(ImgW);
    term_im = (64'(cfg_radius) * 64'd2 * 64'(py)) / 64'(ImgH);
    c_re = {{16{cfg_center_re[CenterW-1]}}, cfg_center_re} - 64'(cfg_radius) + term_re;
    c_im = {{16{cfg_center_im[CenterW-1]}}, cfg_center_im} - 64'(cfg_radius) + term_im;
    cr_w = c_re;
    ci_w = c_im;
    z_re = '0;
    z_im = '0;
    for (int k = 1; k < int'(cfg_max_iter); k++) begin
      zr_w = z_re;
      zi_w = z_im;
      nr = ((zr_w * zr_w - zi_w * zi_w) >>> FracBits) + cr_w;
      ni = ((zr_w * zi_w) >>> (FracBits - 1)) + ci_w;
      // a coordinate that leaves 64 bits counts as escaped
      if (nr[127:63] != {65{nr[63]}} || ni[127:63] != {65{ni[63]}}) begin
        return ColorW'(k);
      end
      z_re = nr[63:0];
      z_im = ni[63:0];
      zr_w = z_re;
      zi_w = z_im;
      mag = zr_w * zr_w + zi_w * zi_w;
      if ((mag >> (2 * FracBits)) >= 128'd100000000) begin
        return ColorW'(k);
      end
    end
    return '0;
  endfunction

  // sender
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        color_q.push_back('{x: pixel_x, y: pixel_y, color: escape_color(pixel_x, pixel_y)});
        accepted_cnt++;
      end
      if (!in_valid || in_ready) begin
        if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_pix = pixel_q.pop_front();
          in_valid <= 1'b1;
          pixel_x  <= drv_pix.x;
          pixel_y  <= drv_pix.y;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and color check
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (color_q.size() == 0) begin
          $display("%0t: color beat %0d with nothing pending", $time, color_index);
          errors++;
        end else begin
          mon_exp = color_q.pop_front();
          checked_cnt++;
          if (color_index !== mon_exp.color) begin
            $display("%0t: pixel (%0d,%0d) color_index expected %0d actual %0d",
                     $time, mon_exp.x, mon_exp.y, mon_exp.color, color_index);
            errors++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("%0t: run timed out after %0d cycles", $time, cycle_cnt);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(meb_reg_e idx, logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    case (idx)
      RegCenterReal: cfg_center_re = val;
      RegCenterImag: cfg_center_im = val;
      RegViewRadius: cfg_radius    = val[RadW-1:0];
      RegMaxIter:    cfg_max_iter  = val[IterW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_pixel(int x, int y);
    pixel_q.push_back('{x: PixW'(x), y: PixW'(y)});
    queued_cnt++;
  endtask

  task automatic wait_idle();
    while (accepted_cnt != queued_cnt || color_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_view(logic [CfgDataW-1:0] c_re, logic [CfgDataW-1:0] c_im,
                          logic [CfgDataW-1:0] radius, logic [CfgDataW-1:0] iters);
    write_reg(RegCenterReal, c_re);
    write_reg(RegCenterImag, c_im);
    write_reg(RegViewRadius, radius);
    write_reg(RegMaxIter, iters);
    view_cnt++;
  endtask

  task automatic random_view(int phase);
    logic [63:0] rnd_re;
    logic [63:0] rnd_im;
    logic [63:0] rad;
    if (phase % 4 == 3) begin
      // anywhere in the full register range
      set_view(CfgDataW'({$urandom, $urandom}), CfgDataW'({$urandom, $urandom}),
               CfgDataW'({$urandom, $urandom}), CfgDataW'($urandom_range(60, 2)));
    end else begin
      // around the set: real in [-2, 0.5), imag in [-1.25, 1.25)
      rnd_re = {$urandom, $urandom} % 64'd43980465111040;
      rnd_im = {$urandom, $urandom} % 64'd43980465111040;
      rad = 64'd1 << $urandom_range(46, 30);
      rad = rad | ({$urandom, $urandom} & (rad - 64'd1));
      set_view(CfgDataW'(rnd_re - 64'd35184372088832),
               CfgDataW'(rnd_im - 64'd21990232555520),
               CfgDataW'(rad), CfgDataW'($urandom_range(100, 2)));
    end
  endtask

  task automatic random_pixels(int n);
    int x;
    int y;
    for (int i = 0; i < n; i++) begin
      x = ($urandom_range(99) < 10) ? $urandom_range(1023, 800) : $urandom_range(799);
      y = ($urandom_range(99) < 10) ? $urandom_range(1023, 800) : $urandom_range(799);
      queue_pixel(x, y);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default view after reset
    queue_pixel(0, 0);
    queue_pixel(799, 799);
    queue_pixel(400, 400);
    queue_pixel(1023, 1023);
    queue_pixel(799, 0);
    queue_pixel(0, 799);
    wait_idle();

    // iteration limit of zero and one
    write_reg(RegMaxIter, CfgDataW'(0));
    queue_pixel(400, 400);
    queue_pixel(0, 0);
    wait_idle();
    write_reg(RegMaxIter, CfgDataW'(1));
    queue_pixel(799, 799);
    queue_pixel(1023, 0);
    wait_idle();

    // zero radius at the top center: escapes at iteration four, seen with a limit of five
    set_view(48'h7FFF_FFFF_FFFF, '0, '0, CfgDataW'(4));
    queue_pixel(5, 5);
    wait_idle();
    write_reg(RegMaxIter, CfgDataW'(5));
    queue_pixel(1023, 0);
    wait_idle();

    // lowest center, highest imag, full radius, full limit
    set_view(48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF);
    queue_pixel(0, 0);
    queue_pixel(1023, 1023);
    queue_pixel(400, 400);
    queue_pixel(0, 1023);
    wait_idle();

    // just right of the cusp: slow escape past 256 iterations
    set_view(48'd4399981511104, '0, '0, CfgDataW'(1000));
    queue_pixel(0, 0);
    queue_pixel(1023, 1023);
    wait_idle();

    for (int p = 0; p < 12; p++) begin
      case (p / 4)
        0: begin
          send_idle_pct = 37;
          recv_idle_pct = 50;
        end
        1: begin
          send_idle_pct = 50;
          recv_idle_pct = 37;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      random_view(p);
      random_pixels(50);
      wait_idle();
    end

    repeat (200) @(posedge clk_i);
    if (color_q.size() != 0) begin
      $display("%0t: %0d colors never arrived", $time, color_q.size());
      errors++;
    end
    $display("%0d pixels over %0d views, %0d colors compared, %0d errors",
             queued_cnt, view_cnt, checked_cnt, errors);
    $display("views ranged from zero radius to the full register range, limits 0 to 65535");
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/meb_pkg.sv
rtl/meb_div.sv
rtl/meb_dp.sv
rtl/meb_ctrl.sv
rtl/mandelbrot_escape_time_pixel_core.sv
tb/tb_top.sv
